// ===== sv/hlp_pkg.sv =====
// Package for the HTTP header length parser: transaction structs, status codes,
// line phase encoding and the key text. No dependencies.
package hlp_pkg;

	localparam int unsigned KEY_LEN = 15;
	localparam int unsigned KEY_POS_W = 4;
	localparam int unsigned HDR_LEN_W = 17;
	localparam int unsigned CONT_LEN_W = 31;
	localparam int unsigned CFG_DATA_W = 31;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [CONT_LEN_W-1:0] VALUE_MAX = '1;
	localparam logic [HDR_LEN_W-1:0] COUNT_MAX = '1;
	localparam logic [CONT_LEN_W-1:0] MAX_CONT_RESET = 31'd1073741824;
	localparam logic [HDR_LEN_W-1:0] MAX_HDR_RESET = 17'd65536;

	localparam logic [7:0] CHAR_CR = 8'h0d;
	localparam logic [7:0] CHAR_LF = 8'h0a;
	localparam logic [7:0] CHAR_SP = 8'h20;
	localparam logic [7:0] CHAR_TAB = 8'h09;
	localparam logic [7:0] CHAR_ZERO = 8'h30;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_CONT = 1'b0,
		REG_MAX_HDR  = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TOO_LARGE = 2'd1,
		ST_HDR_LONG  = 2'd2,
		ST_EARLY_END = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		PH_MATCH    = 5'b00001,
		PH_BLANKS   = 5'b00010,
		PH_DIGITS   = 5'b00100,
		PH_SKIPLINE = 5'b01000,
		PH_DONE     = 5'b10000
	} phase_t;

	// CR LF tracking: none, CR, CR LF, CR LF CR
	typedef enum logic [1:0] {
		EOL_NONE   = 2'd0,
		EOL_CR     = 2'd1,
		EOL_CRLF   = 2'd2,
		EOL_CRLFCR = 2'd3
	} eol_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} hlp_in_t;

	typedef struct packed {
		status_t               status;
		logic [HDR_LEN_W-1:0]  header_length;
		logic [CONT_LEN_W-1:0] content_length;
	} hlp_out_t;

	// Lower-case key text "content-length:"
	function automatic logic [7:0] key_char(input logic [KEY_POS_W-1:0] pos);
		logic [7:0] ch;
		case (pos)
			4'd0:  ch = "c";
			4'd1:  ch = "o";
			4'd2:  ch = "n";
			4'd3:  ch = "t";
			4'd4:  ch = "e";
			4'd5:  ch = "n";
			4'd6:  ch = "t";
			4'd7:  ch = "-";
			4'd8:  ch = "l";
			4'd9:  ch = "e";
			4'd10: ch = "n";
			4'd11: ch = "g";
			4'd12: ch = "t";
			4'd13: ch = "h";
			4'd14: ch = ":";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

// ===== sv/http_header_length_parser_core.sv =====
// HTTP header length parser, top level: input register, per-byte scanner state
// and result register. Depends on hlp_pkg.
//
// Takes one request byte per cycle unless a result waits on out_ready, and
// reports one result per request, when the blank line CR LF CR LF ends the header,
// when the byte limit max_header_length is reached, or when last_byte arrives
// first. The result carries the status, the header length in bytes and the value
// of the first "Content-Length:" line (matched without regard to case, 0 if absent
// or rejected). A result moves from the input register to the result register.
// The rate is set by the scanner state (byte count, CR LF tracker, key matcher,
// digit accumulator), which is updated once per byte.
// Configuration writes take effect for the next byte and are meant for idle time.
module http_header_length_parser_core import hlp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  hlp_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output hlp_out_t              out_data,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [CONT_LEN_W-1:0] max_cont_q;
	logic [HDR_LEN_W-1:0]  max_hdr_q;

	logic    valid_s1;
	hlp_in_t data_s1;

	logic [HDR_LEN_W-1:0]  byte_cnt_q;
	eol_t                  eol_q;
	logic [KEY_POS_W-1:0]  key_pos_q;
	phase_t                phase_q;
	logic [CONT_LEN_W-1:0] len_q;
	logic                  found_q;

	logic                  out_valid_q;
	hlp_out_t              out_data_q;

	logic [HDR_LEN_W-1:0]  byte_cnt_d;
	eol_t                  eol_d;
	logic [KEY_POS_W-1:0]  key_pos_d;
	phase_t                phase_d;
	logic [CONT_LEN_W-1:0] len_d;
	logic                  found_d;
	logic                  hdr_end;
	logic                  produce;
	logic                  advance;
	hlp_out_t              result;
	logic [7:0]            ch;
	logic [7:0]            ch_lc;
	logic                  is_digit;
	logic [3:0]            digit;
	logic [CONT_LEN_W+3:0] prod;
	logic [CONT_LEN_W-1:0] len_acc;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_cont_q <= MAX_CONT_RESET;
			max_hdr_q <= MAX_HDR_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_MAX_CONT: max_cont_q <= cfg_data;
				REG_MAX_HDR: max_hdr_q <= cfg_data[HDR_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign ch = data_s1.data_byte;
	assign ch_lc = (ch inside {["A":"Z"]}) ? ch + 8'd32 : ch;
	assign is_digit = ch inside {["0":"9"]};
	assign digit = 4'(ch - CHAR_ZERO);

	// len * 10 + digit, saturating
	assign prod = {1'b0, len_q, 3'b000} + {3'b000, len_q, 1'b0}
		+ {{(CONT_LEN_W){1'b0}}, digit};
	assign len_acc = (prod > {4'b0000, VALUE_MAX}) ? VALUE_MAX : prod[CONT_LEN_W-1:0];

	always_comb begin
		byte_cnt_d = (byte_cnt_q == COUNT_MAX) ? byte_cnt_q : byte_cnt_q + 1'b1;

		hdr_end = 1'b0;
		if (ch == CHAR_CR) begin
			eol_d = (eol_q == EOL_CRLF) ? EOL_CRLFCR : EOL_CR;
		end else if (ch == CHAR_LF && eol_q == EOL_CR) begin
			eol_d = EOL_CRLF;
		end else if (ch == CHAR_LF && eol_q == EOL_CRLFCR) begin
			eol_d = EOL_NONE;
			hdr_end = 1'b1;
		end else begin
			eol_d = EOL_NONE;
		end

		key_pos_d = key_pos_q;
		phase_d = phase_q;
		len_d = len_q;
		found_d = found_q;
		if (!hdr_end) begin
			case (phase_q)
				PH_MATCH: begin
					if (key_pos_q < KEY_POS_W'(KEY_LEN) && ch_lc == key_char(key_pos_q)) begin
						key_pos_d = key_pos_q + 1'b1;
						if (key_pos_q == KEY_POS_W'(KEY_LEN - 1)) begin
							found_d = 1'b1;
							len_d = '0;
							phase_d = PH_BLANKS;
						end
					end else begin
						key_pos_d = '0;
						phase_d = (ch == CHAR_LF) ? PH_MATCH : PH_SKIPLINE;
					end
				end
				PH_SKIPLINE: begin
					if (ch == CHAR_LF) begin
						key_pos_d = '0;
						phase_d = PH_MATCH;
					end
				end
				PH_BLANKS: begin
					if (ch == CHAR_SP || ch == CHAR_TAB) begin
						phase_d = PH_BLANKS;
					end else if (is_digit) begin
						len_d = len_acc;
						phase_d = PH_DIGITS;
					end else begin
						phase_d = PH_DONE;
					end
				end
				PH_DIGITS: begin
					if (is_digit) begin
						len_d = len_acc;
					end else begin
						phase_d = PH_DONE;
					end
				end
				default: ;
			endcase
		end

		result.header_length = byte_cnt_d;
		result.content_length = '0;
		produce = 1'b1;
		if (hdr_end) begin
			if (found_q && len_q > max_cont_q) begin
				result.status = ST_TOO_LARGE;
			end else begin
				result.status = ST_OK;
				result.content_length = found_q ? len_q : '0;
			end
		end else if (byte_cnt_d >= max_hdr_q) begin
			result.status = ST_HDR_LONG;
		end else if (data_s1.last_byte) begin
			result.status = ST_EARLY_END;
		end else begin
			result.status = ST_OK;
			produce = 1'b0;
		end
	end

	// Process the held byte unless its result would overwrite one not yet taken
	assign advance = valid_s1 && (!out_valid_q || out_ready || !produce);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q <= '0;
			eol_q <= EOL_NONE;
			key_pos_q <= '0;
			phase_q <= PH_MATCH;
			len_q <= '0;
			found_q <= 1'b0;
		end else if (advance) begin
			if (produce) begin
				// request finished: clear for the next one
				byte_cnt_q <= '0;
				eol_q <= EOL_NONE;
				key_pos_q <= '0;
				phase_q <= PH_MATCH;
				len_q <= '0;
				found_q <= 1'b0;
			end else begin
				byte_cnt_q <= byte_cnt_d;
				eol_q <= eol_d;
				key_pos_q <= key_pos_d;
				phase_q <= phase_d;
				len_q <= len_d;
				found_q <= found_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && produce) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q))
		else $error("line phase not one-hot");

	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && produce |=> byte_cnt_q == '0 && !found_q && phase_q == PH_MATCH)
		else $error("scanner state not cleared after a result");

	a_len_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.content_length == '0)
		else $error("content length reported with an error status");

	a_hdr_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.header_length != '0)
		else $error("result with zero header length");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && valid_s1 && produce |-> !advance)
		else $error("pending result would be overwritten");

endmodule

// ===== sim/tb_top.sv =====
// Testbench for http_header_length_parser_core: random request headers, a scanner
// predictor and a per-field result check with random idling on both channels.
// Depends on hlp_pkg and the core RTL.
module tb_top;
	import hlp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 8;
	localparam logic [8*KEY_LEN-1:0] KEY_TEXT = "content-length:";

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	hlp_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	hlp_out_t out_data;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	http_header_length_parser_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Stimulus and expectations
	hlp_in_t byte_q[$];
	logic [7:0] req_q[$];
	hlp_out_t pending_results[$];
	int sent_cnt = 0;
	int mismatch_cnt = 0;
	bit idle_in = 1'b0;
	bit idle_out = 1'b0;
	int in_gap = 0;
	int out_gap = 0;
	logic in_acc = 1'b0;
	int stall_cnt = 0;

	// Scanner state mirror
	logic [CONT_LEN_W-1:0] cfg_max_cont = MAX_CONT_RESET;
	logic [HDR_LEN_W-1:0] cfg_max_hdr = MAX_HDR_RESET;
	logic [HDR_LEN_W-1:0] hdr_bytes = '0;
	eol_t eol_st = EOL_NONE;
	logic [KEY_POS_W-1:0] key_pos = '0;
	phase_t line_st = PH_MATCH;
	logic [CONT_LEN_W-1:0] len_acc = '0;
	bit len_seen = 1'b0;

	task automatic start_new_request();
		hdr_bytes = '0;
		eol_st = EOL_NONE;
		key_pos = '0;
		line_st = PH_MATCH;
		len_acc = '0;
		len_seen = 1'b0;
	endtask

	function automatic logic [CONT_LEN_W-1:0] sat_digit(input logic [CONT_LEN_W-1:0] acc_in,
			input logic [7:0] b);
		logic [63:0] acc;
		acc = {33'd0, acc_in} * 64'd10 + {56'd0, b - CHAR_ZERO};
		if (acc > {33'd0, VALUE_MAX})
			return VALUE_MAX;
		return acc[CONT_LEN_W-1:0];
	endfunction

	function automatic bit is_digit(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	task automatic scan_byte(input hlp_in_t item);
		logic [7:0] b;
		logic [7:0] lc;
		bit hdr_end;
		hlp_out_t res;
		b = item.data_byte;
		hdr_end = 1'b0;
		if (hdr_bytes != COUNT_MAX)
			hdr_bytes = hdr_bytes + 1'b1;
		if (b == CHAR_CR) begin
			if (eol_st == EOL_CRLF)
				eol_st = EOL_CRLFCR;
			else
				eol_st = EOL_CR;
		end else if (b == CHAR_LF && eol_st == EOL_CR) begin
			eol_st = EOL_CRLF;
		end else if (b == CHAR_LF && eol_st == EOL_CRLFCR) begin
			hdr_end = 1'b1;
			eol_st = EOL_NONE;
		end else begin
			eol_st = EOL_NONE;
		end
		// the byte that ends the header is not searched for the key
		if (!hdr_end) begin
			lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
			case (line_st)
				PH_MATCH: begin
					if (key_pos < KEY_LEN &&
							lc == KEY_TEXT[8*(KEY_LEN-1-int'(key_pos)) +: 8]) begin
						key_pos = key_pos + 1'b1;
						if (key_pos == KEY_LEN) begin
							len_seen = 1'b1;
							len_acc = '0;
							line_st = PH_BLANKS;
						end
					end else begin
						key_pos = '0;
						if (b == CHAR_LF)
							line_st = PH_MATCH;
						else
							line_st = PH_SKIPLINE;
					end
				end
				PH_SKIPLINE: begin
					if (b == CHAR_LF) begin
						key_pos = '0;
						line_st = PH_MATCH;
					end
				end
				PH_BLANKS: begin
					if (b == CHAR_SP || b == CHAR_TAB) begin
					end else if (is_digit(b)) begin
						len_acc = sat_digit(len_acc, b);
						line_st = PH_DIGITS;
					end else begin
						line_st = PH_DONE;
					end
				end
				PH_DIGITS: begin
					if (is_digit(b))
						len_acc = sat_digit(len_acc, b);
					else
						line_st = PH_DONE;
				end
				default: begin
				end
			endcase
		end
		if (hdr_end || hdr_bytes >= cfg_max_hdr || item.last_byte) begin
			res.header_length = hdr_bytes;
			res.content_length = '0;
			if (hdr_end) begin
				if (len_seen && len_acc > cfg_max_cont) begin
					res.status = ST_TOO_LARGE;
				end else begin
					res.status = ST_OK;
					if (len_seen)
						res.content_length = len_acc;
				end
			end else if (hdr_bytes >= cfg_max_hdr) begin
				res.status = ST_HDR_LONG;
			end else begin
				res.status = ST_EARLY_END;
			end
			pending_results.push_back(res);
			start_new_request();
		end
	endtask

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $time, msg);
		mismatch_cnt++;
	endtask

	task automatic check_result(input hlp_out_t got);
		hlp_out_t want;
		if (pending_results.size() == 0) begin
			report_mismatch($sformatf("unexpected result status %0d length %0d",
				got.status, got.header_length));
		end else begin
			want = pending_results.pop_front();
			if (got.status != want.status)
				report_mismatch($sformatf("status got %0d want %0d",
					got.status, want.status));
			if (got.header_length != want.header_length)
				report_mismatch($sformatf("header_length got %0d want %0d",
					got.header_length, want.header_length));
			if (got.content_length != want.content_length)
				report_mismatch($sformatf("content_length got %0d want %0d",
					got.content_length, want.content_length));
		end
	endtask

	// Input driver: hold each transaction until accepted
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_acc) begin
			if (in_gap != 0) begin
				in_gap = in_gap - 1;
				in_valid <= 1'b0;
			end else if (byte_q.size() != 0 && idle_in && $urandom_range(0, 9) == 0) begin
				in_gap = $urandom_range(0, 16);
				in_valid <= 1'b0;
			end else if (byte_q.size() != 0) begin
				in_data <= byte_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output backpressure
	always @(negedge clk) begin
		if (out_gap != 0) begin
			out_gap = out_gap - 1;
			out_ready <= 1'b0;
		end else if (idle_out && $urandom_range(0, 9) == 0) begin
			out_gap = $urandom_range(0, 16);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Monitor and watchdog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_acc <= 1'b0;
			stall_cnt = 0;
		end else begin
			in_acc <= in_valid && in_ready;
			if (out_valid && out_ready)
				check_result(out_data);
			if (in_valid && in_ready)
				scan_byte(in_data);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cnt = 0;
			else
				stall_cnt = stall_cnt + 1;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
				$display("[http_header_length_parser_core] ERROR");
				$finish;
			end
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_MAX_CONT)
			cfg_max_cont = val;
		else
			cfg_max_hdr = val[HDR_LEN_W-1:0];
	endtask

	task automatic wait_idle();
		while (byte_q.size() != 0 || in_valid || pending_results.size() != 0)
			@(posedge clk);
		// let a request without a result settle before the next write
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++)
			req_q.push_back(s[i]);
	endtask

	task automatic flush_req(input bit end_last);
		hlp_in_t item;
		for (int i = 0; i < req_q.size(); i++) begin
			item.data_byte = req_q[i];
			item.last_byte = end_last && (i == req_q.size() - 1);
			byte_q.push_back(item);
		end
		sent_cnt += req_q.size();
		req_q.delete();
	endtask

	function automatic logic [7:0] mix_case(input logic [7:0] c);
		if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1)
			return c - 8'd32;
		return c;
	endfunction

	task automatic end_line();
		if ($urandom_range(0, 9) == 0) begin
			req_q.push_back(CHAR_LF);
		end else begin
			req_q.push_back(CHAR_CR);
			req_q.push_back(CHAR_LF);
		end
	endtask

	task automatic add_length_line();
		string key_s;
		int flavor;
		int bad_at;
		int n;
		key_s = "content-length:";
		flavor = $urandom_range(0, 9);
		bad_at = $urandom_range(0, KEY_LEN - 1);
		// indented key never matches
		if (flavor == 0)
			req_q.push_back(CHAR_SP);
		for (int i = 0; i < key_s.len(); i++) begin
			if (flavor == 1 && i == bad_at)
				req_q.push_back("x");
			else
				req_q.push_back(mix_case(key_s[i]));
		end
		n = $urandom_range(0, 3);
		repeat (n) req_q.push_back(($urandom_range(0, 1) == 1) ? CHAR_SP : CHAR_TAB);
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 5);
		repeat (n) req_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
		if ($urandom_range(0, 3) == 0)
			put_str(" ;q");
		end_line();
	endtask

	task automatic add_filler_line();
		int n;
		case ($urandom_range(0, 3))
			0: put_str("Host: h");
			1: put_str("Content-Type: t");
			2: put_str("CONTENT-LENGTH");
			default: begin
				n = $urandom_range(1, 10);
				repeat (n) req_q.push_back(8'($urandom_range(33, 126)));
			end
		endcase
		end_line();
	endtask

	task automatic gen_request();
		int kind;
		int nlines;
		int key_at;
		int n;
		kind = $urandom_range(0, 19);
		if (kind == 0) begin
			n = $urandom_range(1, 12);
			repeat (n) req_q.push_back(8'($urandom_range(0, 255)));
			flush_req($urandom_range(0, 1) == 1);
		end else if (kind == 1) begin
			put_str("\r\n\r\n");
			flush_req(1'b0);
		end else begin
			if ($urandom_range(0, 1) == 1)
				put_str("GET / HTTP/1.1");
			else
				put_str("POST /u HTTP/1.0");
			end_line();
			nlines = $urandom_range(0, 4);
			key_at = $urandom_range(0, nlines);
			for (int i = 0; i <= nlines; i++) begin
				if ((i == key_at && $urandom_range(0, 4) != 0) || $urandom_range(0, 7) == 0)
					add_length_line();
				else
					add_filler_line();
			end
			put_str("\r\n");
			if (kind <= 3) begin
				// cut the request short and mark the cut as the last byte
				n = $urandom_range(1, req_q.size());
				while (req_q.size() > n)
					req_q.delete(req_q.size() - 1);
				flush_req(1'b1);
			end else begin
				flush_req($urandom_range(0, 4) == 0);
			end
		end
	endtask

	initial begin
		logic [CONT_LEN_W-1:0] cont;
		logic [HDR_LEN_W-1:0] hdr;
		int budget;
		int start_cnt;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: bare blank line, lone byte with last set, upper-case key with tab
		idle_in = 1'b1;
		idle_out = 1'b1;
		put_str("\r\n\r\n");
		flush_req(1'b0);
		req_q.push_back(8'hff);
		flush_req(1'b1);
		put_str("CONTENT-LENGTH:\t9\r\n\r\n");
		flush_req(1'b0);
		wait_idle();

		for (int ph = 0; ph < 11; ph++) begin
			// no idling in the last phases
			idle_in = (ph < 9) && ($urandom_range(0, 3) != 0);
			idle_out = (ph < 9) && ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 3))
				0: cont = 31'($urandom_range(0, 1000));
				1: cont = 31'($urandom_range(0, 99999));
				2: cont = 31'($urandom);
				default: cont = VALUE_MAX;
			endcase
			case ($urandom_range(0, 2))
				0: hdr = 17'($urandom_range(4, 64));
				1: hdr = 17'($urandom_range(65, 400));
				default: hdr = MAX_HDR_RESET;
			endcase
			budget = 200;
			case (ph)
				0: begin
					cont = '0;
					hdr = MAX_HDR_RESET;
					budget = 200;
				end
				1: begin
					cont = VALUE_MAX;
					hdr = MAX_HDR_RESET;
					budget = 200;
				end
				2: begin
					hdr = 17'd4;
					budget = 60;
				end
				3: begin
					hdr = 17'd1;
					budget = 10;
				end
				4: begin
					hdr = 17'd0;
					budget = 10;
				end
				5: begin
					hdr = MAX_HDR_RESET;
					budget = 100;
				end
				default: begin
				end
			endcase
			write_reg(REG_MAX_CONT, cont);
			write_reg(REG_MAX_HDR, {{(CFG_DATA_W-HDR_LEN_W){1'b0}}, hdr});
			if (ph == 2) begin
				// header end on the limit byte
				put_str("\r\n\r\n");
				flush_req(1'b0);
			end
			start_cnt = sent_cnt;
			while (sent_cnt - start_cnt < budget)
				gen_request();
			wait_idle();
		end

		if (mismatch_cnt == 0)
			$display("[http_header_length_parser_core] OK");
		else
			$display("[http_header_length_parser_core] ERROR");
		$finish;
	end

endmodule
